// File: hw/rtl/mvam_pkg.sv
// Shared types and codes for the multi-voice audio mixer.
// No dependencies. Used by the mixer top level and its port checker.
package mvam_pkg;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_START = 2'd1,
      MODE_FADE  = 2'd2,
      MODE_TICK  = 2'd3
   } mode_type;

   localparam logic CSR_MASTER_LEFT  = 1'b0;
   localparam logic CSR_MASTER_RIGHT = 1'b1;

   localparam logic [15:0] MASTER_RESET = 16'h8000;

   typedef struct packed {
      mode_type           mode;
      logic [3:0]         voice;
      logic [15:0]        address;
      logic signed [15:0] sample_value;
      logic [15:0]        sound_length;
      logic [23:0]        rate;
      logic [15:0]        target_left;
      logic [15:0]        target_right;
      logic [15:0]        fade_frames;
      logic [15:0]        delay_frames;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
      logic [4:0]         active_voices;
   } rsp_type;

endpackage

// File: hw/rtl/multi_voice_audio_mixer.sv
// Multi-voice stereo wavetable mixer with linear interpolation.
// Depends on mvam_pkg (request/response types, mode codes, register indexes).
//
// Usage:
//   A request is taken when start is high and busy is low. Load, start and
//   zero-length fade requests finish in the accepting cycle; busy stays low.
//   A fade with a nonzero length runs two 32-step restoring divisions on one
//   subtractor, one after the other, with busy high throughout.
//   A frame tick walks the voices one at a time through one shared
//   multiplier and the single sample memory read port; an idle, delayed or
//   ended voice gets only a head state, a sounding one two memory reads,
//   five multiplies and an update. The frame appears on rsp_item for one
//   cycle with rsp_valid, in the cycle busy drops; the receiver must take it
//   then. Master gains are written through csr_we/csr_index/csr_wdata; the
//   user must write them only while idle, the block does not enforce it.
//   Reset clears all voices and sets both master gains to unity. The sample
//   memory is not cleared; reading a word never loaded gives junk.
module multi_voice_audio_mixer
   import mvam_pkg::*;
#(
   parameter int VOICES       = 16,
   parameter int SAMPLE_WORDS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_valid,
   output rsp_type     rsp_item,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW   = $clog2(SAMPLE_WORDS);
   localparam int VW   = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CW   = $clog2(VOICES + 1);
   localparam int ACCW = 50 + VW;
   localparam int KMAX = 17 - AW;
   localparam logic signed [ACCW-1:0] RND    = ACCW'(64'd1 << 29);
   localparam logic signed [ACCW-1:0] SAT_HI = 32767;
   localparam logic signed [ACCW-1:0] SAT_LO = -32768;

   typedef enum logic [10:0] {
      ST_IDLE = 11'b00000000001,
      ST_DIV  = 11'b00000000010,
      ST_HEAD = 11'b00000000100,
      ST_RD0  = 11'b00000001000,
      ST_RD1  = 11'b00000010000,
      ST_INT  = 11'b00000100000,
      ST_M1   = 11'b00001000000,
      ST_M2   = 11'b00010000000,
      ST_M3   = 11'b00100000000,
      ST_M4   = 11'b01000000000,
      ST_UPD  = 11'b10000000000
   } state_type;

   function automatic logic [AW-1:0] wrap_addr(input logic [16:0] a);
      logic [16:0] r;
      r = a;
      for (int k = KMAX; k >= 0; k--) begin
         if ({47'b0, r} >= (64'(SAMPLE_WORDS) << k)) begin
            r = r - 17'(64'(SAMPLE_WORDS) << k);
         end
      end
      return AW'(r);
   endfunction

   function automatic logic [31:0] ramp(input logic [31:0] now,
                                        input logic signed [32:0] step);
      logic signed [34:0] n;
      n = $signed({3'b0, now}) + 35'(step);
      if (n < 0) begin
         return 32'd0;
      end else if (n > 35'sh0FFFFFFFF) begin
         return 32'hFFFFFFFF;
      end else begin
         return n[31:0];
      end
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [ACCW-1:0] acc);
      logic signed [ACCW-1:0] r;
      r = (acc + RND) >>> 30;
      if (r > SAT_HI) begin
         return 16'sh7FFF;
      end else if (r < SAT_LO) begin
         return -16'sh8000;
      end else begin
         return r[15:0];
      end
   endfunction

   function automatic logic [31:0] magnitude(input logic signed [32:0] num);
      logic signed [32:0] m;
      m = num[32] ? -num : num;
      return m[31:0];
   endfunction

   state_type state_ff, state_in;
   logic [VW-1:0] cur_ff, cur_in;
   logic signed [ACCW-1:0] acc_l_ff, acc_l_in, acc_r_ff, acc_r_in;
   logic [CW-1:0] count_ff, count_in;
   logic signed [15:0] s0_ff, s0_in, smp_ff, smp_in;
   logic signed [50:0] prod_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic [15:0] master_l_ff, master_l_in, master_r_ff, master_r_in;

   logic [15:0] div_rem_ff, div_rem_in, div_d_ff, div_d_in;
   logic [31:0] div_q_ff, div_q_in;
   logic div_neg_ff, div_neg_in, div_ch_ff, div_ch_in;
   logic [4:0] div_cnt_ff, div_cnt_in;

   logic               act_ff    [VOICES], act_in    [VOICES];
   logic [15:0]        vstart_ff [VOICES], vstart_in [VOICES];
   logic [15:0]        vlen_ff   [VOICES], vlen_in   [VOICES];
   logic [31:0]        pos_ff    [VOICES], pos_in    [VOICES];
   logic [23:0]        vrate_ff  [VOICES], vrate_in  [VOICES];
   logic [15:0]        delay_ff  [VOICES], delay_in  [VOICES];
   logic [31:0]        now_l_ff  [VOICES], now_l_in  [VOICES];
   logic [31:0]        now_r_ff  [VOICES], now_r_in  [VOICES];
   logic signed [32:0] step_l_ff [VOICES], step_l_in [VOICES];
   logic signed [32:0] step_r_ff [VOICES], step_r_in [VOICES];
   logic [15:0]        goal_l_ff [VOICES], goal_l_in [VOICES];
   logic [15:0]        goal_r_ff [VOICES], goal_r_in [VOICES];
   logic [15:0]        fade_ff   [VOICES], fade_in   [VOICES];

   logic signed [15:0] sample_store [SAMPLE_WORDS];
   logic signed [15:0] mem_q_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic mem_we;

   logic accept, v_ok;
   logic [VW-1:0] req_ix, ix;
   logic [15:0] c_start, c_len, c_delay, c_goal_r, c_fade, idx, frac;
   logic [31:0] c_pos, c_now_l, c_now_r;
   logic [23:0] c_rate;
   logic c_act, has_next;
   logic [AW-1:0] a0, a1;
   logic signed [32:0] num_l, num_r, div_step;
   logic [16:0] div_sh;
   logic [31:0] div_qn;
   logic [32:0] next_pos;
   logic signed [16:0] diff, interp;
   logic signed [33:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [50:0] mul_p;
   logic advance, finish;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign v_ok   = 32'(req_item.voice) < VOICES;
   assign req_ix = VW'(req_item.voice);
   assign ix     = (state_ff == ST_IDLE) ? req_ix : cur_ff;

   assign c_act    = act_ff[ix];
   assign c_start  = vstart_ff[ix];
   assign c_len    = vlen_ff[ix];
   assign c_pos    = pos_ff[ix];
   assign c_rate   = vrate_ff[ix];
   assign c_delay  = delay_ff[ix];
   assign c_now_l  = now_l_ff[ix];
   assign c_now_r  = now_r_ff[ix];
   assign c_goal_r = goal_r_ff[ix];
   assign c_fade   = fade_ff[ix];
   assign idx      = c_pos[31:16];
   assign frac     = c_pos[15:0];

   assign has_next = ({1'b0, idx} + 17'd1) < {1'b0, c_len};
   assign a0 = wrap_addr({1'b0, c_start} + {1'b0, idx});
   assign a1 = wrap_addr({1'b0, c_start} + {1'b0, idx} + {16'b0, has_next});
   assign rd_addr = (state_ff == ST_RD0) ? a1 : a0;
   assign wr_addr = wrap_addr({1'b0, req_item.address});
   assign mem_we  = accept && (req_item.mode == MODE_LOAD);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_store[wr_addr] <= req_item.sample_value;
      end
      mem_q_ff <= sample_store[rd_addr];
   end

   assign num_l = $signed({1'b0, req_item.target_left, 16'b0}) - $signed({1'b0, c_now_l});
   assign num_r = $signed({1'b0, c_goal_r, 16'b0}) - $signed({1'b0, c_now_r});
   assign div_sh = {div_rem_ff, div_q_ff[31]};
   assign div_qn = {div_q_ff[30:0], (div_sh >= {1'b0, div_d_ff})};
   assign div_step = div_neg_ff ? -$signed({1'b0, div_qn}) : $signed({1'b0, div_qn});

   assign diff     = $signed({mem_q_ff[15], mem_q_ff}) - $signed({s0_ff[15], s0_ff});
   assign interp   = $signed({s0_ff[15], s0_ff}) + $signed(prod_ff[32:16]);
   assign next_pos = {1'b0, c_pos} + {9'b0, c_rate};

   always_comb begin
      unique case (state_ff)
         ST_RD1: begin
            mul_a = 34'(diff);
            mul_b = $signed({1'b0, frac});
         end
         ST_M1: begin
            mul_a = 34'(smp_ff);
            mul_b = $signed({1'b0, c_now_l[31:16]});
         end
         ST_M2: begin
            mul_a = 34'($signed(prod_ff[32:0]));
            mul_b = $signed({1'b0, master_l_ff});
         end
         ST_M3: begin
            mul_a = 34'(smp_ff);
            mul_b = $signed({1'b0, c_now_r[31:16]});
         end
         ST_M4: begin
            mul_a = 34'($signed(prod_ff[32:0]));
            mul_b = $signed({1'b0, master_r_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      acc_l_in     = acc_l_ff;
      acc_r_in     = acc_r_ff;
      count_in     = count_ff;
      s0_in        = s0_ff;
      smp_in       = smp_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      master_l_in  = master_l_ff;
      master_r_in  = master_r_ff;
      div_rem_in   = div_rem_ff;
      div_d_in     = div_d_ff;
      div_q_in     = div_q_ff;
      div_neg_in   = div_neg_ff;
      div_ch_in    = div_ch_ff;
      div_cnt_in   = div_cnt_ff;
      act_in       = act_ff;
      vstart_in    = vstart_ff;
      vlen_in      = vlen_ff;
      pos_in       = pos_ff;
      vrate_in     = vrate_ff;
      delay_in     = delay_ff;
      now_l_in     = now_l_ff;
      now_r_in     = now_r_ff;
      step_l_in    = step_l_ff;
      step_r_in    = step_r_ff;
      goal_l_in    = goal_l_ff;
      goal_r_in    = goal_r_ff;
      fade_in      = fade_ff;
      advance      = 1'b0;
      finish       = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_MASTER_LEFT:  master_l_in = csr_wdata;
            CSR_MASTER_RIGHT: master_r_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_item.mode)
                  MODE_LOAD: ;
                  MODE_START: begin
                     if (v_ok) begin
                        act_in[req_ix]    = 1'b1;
                        vstart_in[req_ix] = req_item.address;
                        vlen_in[req_ix]   = req_item.sound_length;
                        pos_in[req_ix]    = '0;
                        vrate_in[req_ix]  = req_item.rate;
                        delay_in[req_ix]  = req_item.delay_frames;
                        now_l_in[req_ix]  = {req_item.target_left, 16'b0};
                        now_r_in[req_ix]  = {req_item.target_right, 16'b0};
                        step_l_in[req_ix] = '0;
                        step_r_in[req_ix] = '0;
                        goal_l_in[req_ix] = req_item.target_left;
                        goal_r_in[req_ix] = req_item.target_right;
                        fade_in[req_ix]   = '0;
                     end
                  end
                  MODE_FADE: begin
                     if (v_ok) begin
                        goal_l_in[req_ix] = req_item.target_left;
                        goal_r_in[req_ix] = req_item.target_right;
                        if (req_item.fade_frames == 16'd0) begin
                           now_l_in[req_ix]  = {req_item.target_left, 16'b0};
                           now_r_in[req_ix]  = {req_item.target_right, 16'b0};
                           step_l_in[req_ix] = '0;
                           step_r_in[req_ix] = '0;
                           fade_in[req_ix]   = '0;
                        end else begin
                           fade_in[req_ix] = req_item.fade_frames;
                           cur_in          = req_ix;
                           div_d_in        = req_item.fade_frames;
                           div_rem_in      = '0;
                           div_q_in        = magnitude(num_l);
                           div_neg_in      = num_l[32];
                           div_ch_in       = 1'b0;
                           div_cnt_in      = '0;
                           state_in        = ST_DIV;
                        end
                     end
                  end
                  MODE_TICK: begin
                     cur_in   = '0;
                     acc_l_in = '0;
                     acc_r_in = '0;
                     count_in = '0;
                     state_in = ST_HEAD;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            if (div_sh >= {1'b0, div_d_ff}) begin
               div_rem_in = 16'(div_sh - {1'b0, div_d_ff});
            end else begin
               div_rem_in = div_sh[15:0];
            end
            div_q_in   = div_qn;
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) begin
               if (!div_ch_ff) begin
                  step_l_in[cur_ff] = div_step;
                  div_rem_in        = '0;
                  div_q_in          = magnitude(num_r);
                  div_neg_in        = num_r[32];
                  div_ch_in         = 1'b1;
                  div_cnt_in        = '0;
               end else begin
                  step_r_in[cur_ff] = div_step;
                  state_in          = ST_IDLE;
               end
            end
         end
         ST_HEAD: begin
            if (!c_act) begin
               advance = 1'b1;
            end else if (c_delay != 16'd0) begin
               delay_in[cur_ff] = c_delay - 16'd1;
               count_in         = count_ff + CW'(1);
               advance          = 1'b1;
            end else if (idx >= c_len) begin
               act_in[cur_ff] = 1'b0;
               advance        = 1'b1;
            end else begin
               state_in = ST_RD0;
            end
         end
         ST_RD0: begin
            s0_in    = mem_q_ff;
            state_in = ST_RD1;
         end
         ST_RD1: state_in = ST_INT;
         ST_INT: begin
            smp_in   = interp[15:0];
            state_in = ST_M1;
         end
         ST_M1: state_in = ST_M2;
         ST_M2: state_in = ST_M3;
         ST_M3: begin
            acc_l_in = acc_l_ff + ACCW'(prod_ff);
            state_in = ST_M4;
         end
         ST_M4: state_in = ST_UPD;
         ST_UPD: begin
            acc_r_in = acc_r_ff + ACCW'(prod_ff);
            if (c_fade != 16'd0) begin
               fade_in[cur_ff] = c_fade - 16'd1;
               if (c_fade == 16'd1) begin
                  now_l_in[cur_ff]  = {goal_l_ff[cur_ff], 16'b0};
                  now_r_in[cur_ff]  = {goal_r_ff[cur_ff], 16'b0};
                  step_l_in[cur_ff] = '0;
                  step_r_in[cur_ff] = '0;
               end else begin
                  now_l_in[cur_ff] = ramp(c_now_l, step_l_ff[cur_ff]);
                  now_r_in[cur_ff] = ramp(c_now_r, step_r_ff[cur_ff]);
               end
            end
            pos_in[cur_ff] = next_pos[31:0];
            if (next_pos[32:16] >= {1'b0, c_len}) begin
               act_in[cur_ff] = 1'b0;
            end else begin
               count_in = count_ff + CW'(1);
            end
            advance = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase

      if (advance) begin
         if (cur_ff == VW'(VOICES - 1)) begin
            finish = 1'b1;
         end else begin
            cur_in   = cur_ff + VW'(1);
            state_in = ST_HEAD;
         end
      end

      if (finish) begin
         state_in               = ST_IDLE;
         rsp_valid_in           = 1'b1;
         rsp_in.left_sample     = sat16(acc_l_in);
         rsp_in.right_sample    = sat16(acc_r_in);
         rsp_in.active_voices   = (int'(count_in) > 31) ? 5'd31 : 5'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         master_l_ff  <= MASTER_RESET;
         master_r_ff  <= MASTER_RESET;
         for (int i = 0; i < VOICES; i++) begin
            act_ff[i]    <= 1'b0;
            vstart_ff[i] <= '0;
            vlen_ff[i]   <= '0;
            pos_ff[i]    <= '0;
            vrate_ff[i]  <= '0;
            delay_ff[i]  <= '0;
            now_l_ff[i]  <= '0;
            now_r_ff[i]  <= '0;
            step_l_ff[i] <= '0;
            step_r_ff[i] <= '0;
            goal_l_ff[i] <= '0;
            goal_r_ff[i] <= '0;
            fade_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         master_l_ff  <= master_l_in;
         master_r_ff  <= master_r_in;
         act_ff       <= act_in;
         vstart_ff    <= vstart_in;
         vlen_ff      <= vlen_in;
         pos_ff       <= pos_in;
         vrate_ff     <= vrate_in;
         delay_ff     <= delay_in;
         now_l_ff     <= now_l_in;
         now_r_ff     <= now_r_in;
         step_l_ff    <= step_l_in;
         step_r_ff    <= step_r_in;
         goal_l_ff    <= goal_l_in;
         goal_r_ff    <= goal_r_in;
         fade_ff      <= fade_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      acc_l_ff   <= acc_l_in;
      acc_r_ff   <= acc_r_in;
      count_ff   <= count_in;
      s0_ff      <= s0_in;
      smp_ff     <= smp_in;
      prod_ff    <= mul_p;
      rsp_ff     <= rsp_in;
      div_rem_ff <= div_rem_in;
      div_d_ff   <= div_d_in;
      div_q_ff   <= div_q_in;
      div_neg_ff <= div_neg_in;
      div_ch_ff  <= div_ch_in;
      div_cnt_ff <= div_cnt_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// File: hw/rtl/mvam_checker.sv
// Port-level checks for the multi-voice audio mixer, bound to the top level.
// Depends on mvam_pkg for the request type and mode codes.
module mvam_checker
   import mvam_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_valid
);

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while busy");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.mode == MODE_TICK) |=> busy)
      else $error("frame request did not raise busy");

   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.mode == MODE_LOAD) |=> (!busy && !rsp_valid))
      else $error("load request stalled or produced a response");

endmodule

bind multi_voice_audio_mixer mvam_checker u_mvam_checker (.*);

// File: bench/multi_voice_audio_mixer_test.sv
// Self-checking testbench for the multi-voice audio mixer: directed and random
// requests under sender idling, checked frame by frame against a mixer predictor.
// Depends on mvam_pkg and multi_voice_audio_mixer.
module multi_voice_audio_mixer_test;
   import mvam_pkg::*;

   localparam int NVOICE      = 16;
   localparam int WIN_BASE    = 65520;  // preloaded window wraps through address 0
   localparam int WIN_WORDS   = 32;
   localparam int SETTLE      = 300;
   localparam int CYCLE_LIMIT = 2000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_item = '0;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   multi_voice_audio_mixer dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // mixer predictor state
   logic [15:0] gain_left = MASTER_RESET;
   logic [15:0] gain_right = MASTER_RESET;
   logic [15:0] wave_mem [65536];
   logic        playing [NVOICE];
   logic [15:0] first_addr [NVOICE];
   logic [15:0] sound_len [NVOICE];
   logic [31:0] play_pos [NVOICE];
   logic [23:0] play_rate [NVOICE];
   logic [15:0] hold_frames [NVOICE];
   logic [31:0] vol_left [NVOICE];
   logic [31:0] vol_right [NVOICE];
   longint      step_left [NVOICE];
   longint      step_right [NVOICE];
   logic [15:0] goal_left [NVOICE];
   logic [15:0] goal_right [NVOICE];
   logic [15:0] fade_left_frames [NVOICE];

   rsp_type frames_due [$];
   int      errors = 0;
   int      cycles = 0;
   int      idle_pct = 0;

   initial begin
      for (int i = 0; i < NVOICE; i++) begin
         playing[i] = 1'b0; first_addr[i] = '0; sound_len[i] = '0; play_pos[i] = '0;
         play_rate[i] = '0; hold_frames[i] = '0; vol_left[i] = '0; vol_right[i] = '0;
         step_left[i] = 0; step_right[i] = 0; goal_left[i] = '0; goal_right[i] = '0;
         fade_left_frames[i] = '0;
      end
   end

   function automatic longint read_wave(logic [15:0] base, logic [31:0] offset);
      logic [15:0] a;
      a = 16'(base + offset);
      return longint'($signed(wave_mem[a]));
   endfunction

   function automatic logic [15:0] round_sat(longint acc);
      longint r;
      r = (acc + (longint'(1) <<< 29)) >>> 30;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   function automatic logic [31:0] ramp_volume(logic [31:0] now, longint stp);
      longint n;
      n = longint'(now) + stp;
      if (n < 0) n = 0;
      if (n > 64'hFFFF_FFFF) n = 64'hFFFF_FFFF;
      return 32'(n);
   endfunction

   function automatic void mix_frame();
      longint acc_l, acc_r, s0, s1, smp, next;
      logic [31:0] idx, frac;
      int count;
      rsp_type f;
      acc_l = 0; acc_r = 0; count = 0;
      for (int i = 0; i < NVOICE; i++) begin
         if (!playing[i]) continue;
         if (hold_frames[i] > 0) begin
            hold_frames[i]--;
            count++;
            continue;
         end
         idx = play_pos[i] >> 16;
         frac = play_pos[i] & 32'hFFFF;
         if (idx >= sound_len[i]) begin
            playing[i] = 1'b0;
            continue;
         end
         s0 = read_wave(first_addr[i], idx);
         s1 = (idx + 1 < sound_len[i]) ? read_wave(first_addr[i], idx + 1) : s0;
         smp = (s0 * longint'(65536 - frac) + s1 * longint'(frac)) >>> 16;
         acc_l += smp * longint'(vol_left[i] >> 16) * longint'(gain_left);
         acc_r += smp * longint'(vol_right[i] >> 16) * longint'(gain_right);
         if (fade_left_frames[i] > 0) begin
            vol_left[i] = ramp_volume(vol_left[i], step_left[i]);
            vol_right[i] = ramp_volume(vol_right[i], step_right[i]);
            fade_left_frames[i]--;
            if (fade_left_frames[i] == 0) begin
               vol_left[i] = {goal_left[i], 16'h0};
               vol_right[i] = {goal_right[i], 16'h0};
               step_left[i] = 0;
               step_right[i] = 0;
            end
         end
         next = longint'(play_pos[i]) + longint'(play_rate[i]);
         play_pos[i] = 32'(next);
         if ((next >> 16) >= sound_len[i]) begin
            playing[i] = 1'b0;
            continue;
         end
         count++;
      end
      if (count > 31) count = 31;
      f.left_sample = round_sat(acc_l);
      f.right_sample = round_sat(acc_r);
      f.active_voices = 5'(count);
      frames_due.push_back(f);
   endfunction

   function automatic void apply_request(req_type r);
      int v;
      v = int'(r.voice);
      case (r.mode)
         MODE_LOAD: wave_mem[r.address] = r.sample_value;
         MODE_START: begin
            playing[v] = 1'b1;
            first_addr[v] = r.address;
            sound_len[v] = r.sound_length;
            play_pos[v] = '0;
            play_rate[v] = r.rate;
            hold_frames[v] = r.delay_frames;
            vol_left[v] = {r.target_left, 16'h0};
            vol_right[v] = {r.target_right, 16'h0};
            step_left[v] = 0; step_right[v] = 0;
            goal_left[v] = r.target_left;
            goal_right[v] = r.target_right;
            fade_left_frames[v] = '0;
         end
         MODE_FADE: begin
            goal_left[v] = r.target_left;
            goal_right[v] = r.target_right;
            if (r.fade_frames == 0) begin
               vol_left[v] = {r.target_left, 16'h0};
               vol_right[v] = {r.target_right, 16'h0};
               step_left[v] = 0; step_right[v] = 0;
               fade_left_frames[v] = '0;
            end else begin
               step_left[v] = ((longint'(r.target_left) <<< 16) - longint'(vol_left[v]))
                              / longint'(r.fade_frames);
               step_right[v] = ((longint'(r.target_right) <<< 16) - longint'(vol_right[v]))
                               / longint'(r.fade_frames);
               fade_left_frames[v] = r.fade_frames;
            end
         end
         default: mix_frame();
      endcase
   endfunction

   // sends one request; start stays high unless an idle gap lowers it
   task automatic send_request(req_type r);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_item <= r;
      start <= 1'b1;
      do @(negedge clock); while (busy);
      @(posedge clock);
      apply_request(r);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_master(logic [0:0] idx, logic [15:0] value);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MASTER_LEFT) gain_left = value;
      else gain_right = value;
   endtask

   function automatic req_type make_req(mode_type m, int v, int addr, int val);
      req_type r;
      r = '0;
      r.mode = m;
      r.voice = 4'(v);
      r.address = 16'(addr);
      r.sample_value = 16'(val);
      return r;
   endfunction

   function automatic req_type make_start(int v, int off, int len, int rt, int tl, int tr,
                                          int dly);
      req_type r;
      r = make_req(MODE_START, v, WIN_BASE + off, 0);
      r.sound_length = 16'(len);
      r.rate = 24'(rt);
      r.target_left = 16'(tl);
      r.target_right = 16'(tr);
      r.delay_frames = 16'(dly);
      return r;
   endfunction

   function automatic req_type make_fade(int v, int tl, int tr, int frames);
      req_type r;
      r = make_req(MODE_FADE, v, 0, 0);
      r.target_left = 16'(tl);
      r.target_right = 16'(tr);
      r.fade_frames = 16'(frames);
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int roll, off;
      r.mode = mode_type'($urandom_range(0, 3));
      r.voice = 4'($urandom);
      r.address = 16'($urandom);
      r.sample_value = 16'($urandom);
      r.sound_length = 16'($urandom);
      r.rate = 24'($urandom);
      r.target_left = 16'($urandom);
      r.target_right = 16'($urandom);
      r.fade_frames = 16'($urandom);
      r.delay_frames = 16'($urandom);
      roll = $urandom_range(99);
      if (roll < 25) begin
         r.mode = MODE_LOAD;
         if ($urandom_range(9) < 7) r.address = 16'(WIN_BASE + $urandom_range(0, WIN_WORDS - 1));
      end else if (roll < 45) begin
         r.mode = MODE_START;
         off = $urandom_range(0, WIN_WORDS - 2);
         r.address = 16'(WIN_BASE + off);
         if ($urandom_range(4) == 0) r.rate = '0;
         else begin
            r.sound_length = 16'($urandom_range(0, WIN_WORDS - off));
            if ($urandom_range(2) != 0) r.rate = 24'($urandom_range(0, 24'h30000));
         end
         if ($urandom_range(19) != 0) r.delay_frames = 16'($urandom_range(0, 3));
      end else if (roll < 60) begin
         r.mode = MODE_FADE;
         if ($urandom_range(9) != 0) r.fade_frames = 16'($urandom_range(0, 20));
      end else r.mode = MODE_TICK;
      return r;
   endfunction

   task automatic preload_window();
      for (int i = 0; i < WIN_WORDS; i++)
         send_request(make_req(MODE_LOAD, 0, WIN_BASE + i, $urandom_range(0, 65535)));
   endtask

   task automatic test_directed_cases();
      req_type t;
      send_request(make_req(MODE_LOAD, 0, 65534, -32768));
      send_request(make_req(MODE_LOAD, 0, 65535, 32767));
      send_request(make_req(MODE_LOAD, 0, 0, -32768));
      t = make_req(MODE_TICK, 0, 0, 0);
      send_request(t);  // empty mix
      // wrap through address 0, interpolation, last sample held
      send_request(make_start(0, 14, 4, 24'h8000, 65535, 65535, 0));
      send_request(make_start(1, 14, 2, 24'h8000, 65535, 0, 0));
      send_request(make_start(2, 0, 0, 24'h10000, 100, 100, 0));  // empty sound
      send_request(make_start(15, 3, 5, 0, 40000, 20000, 2));  // delayed, zero rate
      send_request(make_start(3, 5, 3, 24'hFFFFFF, 65535, 65535, 0));  // huge rate
      send_request(make_fade(7, 1000, 2000, 3));  // idle voice
      send_request(make_fade(15, 0, 65535, 4));
      repeat (6) send_request(t);
      send_request(make_fade(15, 12345, 0, 0));
      send_request(make_start(15, 0, 65535, 0, 65535, 65535, 0));  // restart
      send_request(t);
      send_request(make_fade(15, 0, 0, 65535));
      repeat (2) send_request(t);
   endtask

   task automatic test_random_mix(int pct, int count);
      idle_pct = pct;
      for (int i = 0; i < count; i++) send_request(random_request());
      idle_pct = 0;
   endtask

   task automatic test_master_gains();
      write_master(CSR_MASTER_LEFT, 16'hFFFF);
      write_master(CSR_MASTER_RIGHT, 16'h0000);
      test_random_mix(0, 150);
      write_master(CSR_MASTER_LEFT, 16'h0000);
      write_master(CSR_MASTER_RIGHT, 16'hFFFF);
      test_random_mix(48, 150);
      write_master(CSR_MASTER_LEFT, 16'($urandom));
      write_master(CSR_MASTER_RIGHT, 16'($urandom));
      test_random_mix(29, 150);
      write_master(CSR_MASTER_LEFT, MASTER_RESET);
      write_master(CSR_MASTER_RIGHT, MASTER_RESET);
   endtask

   always @(negedge clock) begin
      if (!reset && rsp_valid) begin
         if (frames_due.size() == 0) begin
            $display("%0t unexpected frame: actual %p", $time, rsp_item);
            errors++;
         end else begin
            rsp_type e;
            e = frames_due.pop_front();
            if (rsp_item.left_sample !== e.left_sample) begin
               $display("%0t left_sample: expected %0d actual %0d", $time,
                        e.left_sample, rsp_item.left_sample);
               errors++;
            end
            if (rsp_item.right_sample !== e.right_sample) begin
               $display("%0t right_sample: expected %0d actual %0d", $time,
                        e.right_sample, rsp_item.right_sample);
               errors++;
            end
            if (rsp_item.active_voices !== e.active_voices) begin
               $display("%0t active_voices: expected %0d actual %0d", $time,
                        e.active_voices, rsp_item.active_voices);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      preload_window();
      test_directed_cases();
      test_random_mix(0, 250);
      test_random_mix(48, 200);
      test_random_mix(29, 200);
      test_master_gains();
      wait_idle();
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
